// File: hw/rtl/rsort_pkg.sv
// Shared constants and helper functions for the LSD radix sort block.
// Used by rsort_div and lsd_radix_sort_core; no dependencies of its own.
package rsort_pkg;

    // Fixed port widths
    localparam int RS_VALUE_W    = 16;
    localparam int RS_BASE_W     = 5;

    // Digit base limits and reset value
    localparam int RS_BUCKETS    = 19;
    localparam int RS_BASE_MIN   = 2;
    localparam int RS_BASE_RESET = 10;

    // Reciprocal scaling used by the divider
    localparam int RS_RECIP_SHIFT = 20;
    localparam int RS_RECIP_W     = 20;

    // Default parameter values for the top level
    localparam int RS_MAX_ITEMS_DEF  = 64;
    localparam int RS_VALUE_BITS_DEF = 16;

    // Clamp the configured base into the supported range
    function automatic logic [RS_BASE_W-1:0] rs_eff_base(input logic [RS_BASE_W-1:0] b);
        logic [RS_BASE_W-1:0] res;
        if (b < RS_BASE_W'(RS_BASE_MIN)) begin
            res = RS_BASE_W'(RS_BASE_MIN);
        end else if (b > RS_BASE_W'(RS_BUCKETS)) begin
            res = RS_BASE_W'(RS_BUCKETS);
        end else begin
            res = b;
        end
        return res;
    endfunction

    // floor(2^20 / b) for every legal base
    function automatic logic [RS_RECIP_W-1:0] rs_recip(input logic [RS_BASE_W-1:0] b);
        logic [RS_RECIP_W-1:0] res;
        case (b)
            5'd2:    res = 20'd524288;
            5'd3:    res = 20'd349525;
            5'd4:    res = 20'd262144;
            5'd5:    res = 20'd209715;
            5'd6:    res = 20'd174762;
            5'd7:    res = 20'd149796;
            5'd8:    res = 20'd131072;
            5'd9:    res = 20'd116508;
            5'd10:   res = 20'd104857;
            5'd11:   res = 20'd95325;
            5'd12:   res = 20'd87381;
            5'd13:   res = 20'd80659;
            5'd14:   res = 20'd74898;
            5'd15:   res = 20'd69905;
            5'd16:   res = 20'd65536;
            5'd17:   res = 20'd61680;
            5'd18:   res = 20'd58254;
            5'd19:   res = 20'd55188;
            default: res = 20'd55188;
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/rsort_div.sv
// Shared divider: quotient and remainder of a value by the digit base.
// Reciprocal multiply, then one correction step; depends on rsort_pkg.
module rsort_div
    import rsort_pkg::*;
#(
    parameter int W = RS_VALUE_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [W-1:0]         i_num,
    input  logic [RS_BASE_W-1:0] i_base,
    output logic                 o_done,
    output logic [W-1:0]         o_quo,
    output logic [RS_BASE_W-1:0] o_rem
);

    localparam int PROD_W = W + RS_RECIP_W;
    localparam int QB_W   = W + RS_BASE_W;

    logic                 r_st1;
    logic                 r_done;
    logic [W-1:0]         r_num;
    logic [PROD_W-1:0]    r_prod;
    logic [W-1:0]         r_quo;
    logic [RS_BASE_W-1:0] r_rem;

    logic [W-1:0]         w_qe;
    logic [QB_W-1:0]      w_qb;
    logic [QB_W-1:0]      w_diff;
    logic [5:0]           w_rraw;
    logic                 w_fix;

    // Estimate is floor(q/b) or one less; fix with one compare and subtract
    assign w_qe   = r_prod[PROD_W-1:RS_RECIP_SHIFT];
    assign w_qb   = QB_W'(w_qe * i_base);
    assign w_diff = QB_W'(r_num) - w_qb;
    assign w_rraw = w_diff[5:0];
    assign w_fix  = (w_rraw >= 6'(i_base));

    // Control: start feeds the product stage, product stage feeds done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_st1  <= i_start;
            r_done <= r_st1;
        end
    end

    // Datapath: multiply, then correct
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_prod <= PROD_W'(i_num) * PROD_W'(rs_recip(i_base));
        end
        if (r_st1) begin
            if (w_fix) begin
                r_quo <= w_qe + W'(1);
                r_rem <= RS_BASE_W'(w_rraw - 6'(i_base));
            end else begin
                r_quo <= w_qe;
                r_rem <= RS_BASE_W'(w_rraw);
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: hw/rtl/lsd_radix_sort_core.sv
// LSD radix sort block: load, counting-sort passes, ascending emission.
// Channels: input transfer (i_in_valid / o_in_ready) carries i_value and i_last;
// output transfer (o_out_valid / i_out_ready) carries o_value_res, o_last_res,
// o_overflow. i_cfg_we writes the digit base (clamped to 2..19).
// Loading takes one cycle per item; items beyond MAX_ITEMS are dropped and
// flagged on every result of the set. The item marked last starts the sort,
// and o_in_ready stays low until the final result has been transferred.
// Sort: with n stored items and base b, each digit pass runs the digit step
// around the shared divider for each item, the bucket offsets for each of the
// b buckets, the scatter and the copy back for each item, with a check ahead
// of each pass and one at the end. The number of passes is the number of
// base-b digits of the largest stored value (none when it is 0).
// Emission reads, registers and presents one result at a time; a stall
// holds the current result in the output register until it is transferred.
// Reset (synchronous, active low) empties the store, clears the overflow flag
// and sets the base to 10; no clearing pass is needed.
// Depends on rsort_pkg and rsort_div.
module lsd_radix_sort_core
    import rsort_pkg::*;
#(
    parameter int MAX_ITEMS  = RS_MAX_ITEMS_DEF,
    parameter int VALUE_BITS = RS_VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [RS_VALUE_W-1:0] i_value,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [RS_VALUE_W-1:0] o_value_res,
    output logic                  o_last_res,
    output logic                  o_overflow,
    input  logic                  i_cfg_we,
    input  logic [RS_BASE_W-1:0]  i_cfg_wdata
);

    localparam int SW = (VALUE_BITS < RS_VALUE_W) ? VALUE_BITS : RS_VALUE_W;
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = SW + RS_BASE_W;
    localparam int EW = 2 * SW;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHK,
        S_DG_RD,
        S_DG_DIV,
        S_DG_WAIT,
        S_PFX,
        S_SC_RD,
        S_SC_WR,
        S_CP_RD,
        S_CP_WR,
        S_EM_RD,
        S_EM_OUT,
        S_EM_HOLD
    } t_state;

    t_state               r_state;
    logic [RS_BASE_W-1:0] r_base;
    logic [CW-1:0]        r_count;
    logic                 r_drop;
    logic [SW-1:0]        r_maxv;
    logic [PW-1:0]        r_place;
    logic [IW-1:0]        r_idx;
    logic [RS_BASE_W-1:0] r_pfx;
    logic [CW-1:0]        r_acc;
    logic [CW-1:0]        r_cnt [RS_BUCKETS];
    logic                 r_out_valid;
    logic [RS_VALUE_W-1:0] r_out_value;
    logic                 r_out_last;
    logic                 r_out_ovf;

    // Element word: value in the upper half, running quotient in the lower
    logic [EW-1:0]        r_elem_mem [MAX_ITEMS];
    logic [EW-1:0]        r_bkt_mem  [MAX_ITEMS];
    logic [RS_BASE_W-1:0] r_dig_mem  [MAX_ITEMS];
    logic [EW-1:0]        r_rd;
    logic [EW-1:0]        r_brd;
    logic [RS_BASE_W-1:0] r_drd;

    logic                 w_base_ok;
    logic [RS_BASE_W-1:0] w_base;
    logic                 w_full;
    logic                 w_in_xfer;
    logic                 w_idx_last;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [SW-1:0]        w_quo;
    logic [RS_BASE_W-1:0] w_rem;
    logic [SW-1:0]        w_in_v;
    logic                 w_elem_we;
    logic [IW-1:0]        w_elem_waddr;
    logic [EW-1:0]        w_elem_wdata;
    logic                 w_dig_we;
    logic                 w_bkt_we;
    logic [IW-1:0]        w_bkt_waddr;

    assign w_base     = rs_eff_base(r_base);
    assign w_base_ok  = (r_base == w_base);
    assign w_full     = (r_count == CW'(MAX_ITEMS));
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_idx_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign w_in_v     = i_value[SW-1:0];
    assign w_div_start = (r_state == S_DG_DIV);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= RS_BASE_W'(RS_BASE_RESET);
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // Shared divider: quotient by base and digit for each element
    rsort_div #(
        .W (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_rd[SW-1:0]),
        .i_base  (w_base),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // Memory write steering
    always_comb begin
        w_elem_we    = 1'b0;
        w_elem_waddr = r_idx;
        w_elem_wdata = r_brd;
        case (r_state)
            S_LOAD: begin
                w_elem_we    = w_in_xfer && !w_full;
                w_elem_waddr = r_count[IW-1:0];
                w_elem_wdata = {w_in_v, w_in_v};
            end
            S_DG_WAIT: begin
                w_elem_we    = w_div_done;
                w_elem_wdata = {r_rd[EW-1:SW], w_quo};
            end
            S_CP_WR: begin
                w_elem_we    = 1'b1;
            end
            default: begin
                w_elem_we    = 1'b0;
            end
        endcase
    end

    assign w_dig_we    = (r_state == S_DG_WAIT) && w_div_done;
    assign w_bkt_we    = (r_state == S_SC_WR);
    assign w_bkt_waddr = r_cnt[r_drd][IW-1:0];

    // Element store
    always_ff @(posedge i_clk) begin
        if (w_elem_we) begin
            r_elem_mem[w_elem_waddr] <= w_elem_wdata;
        end
        r_rd <= r_elem_mem[r_idx];
    end

    // Digit store
    always_ff @(posedge i_clk) begin
        if (w_dig_we) begin
            r_dig_mem[r_idx] <= w_rem;
        end
        r_drd <= r_dig_mem[r_idx];
    end

    // Bucket store
    always_ff @(posedge i_clk) begin
        if (w_bkt_we) begin
            r_bkt_mem[w_bkt_waddr] <= r_rd;
        end
        r_brd <= r_bkt_mem[r_idx];
    end

    // Sequencer: load, digit passes, emission
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_maxv      <= '0;
            r_place     <= PW'(1);
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (i_in_valid) begin
                        if (!w_full) begin
                            r_count <= r_count + CW'(1);
                            if (w_in_v > r_maxv) begin
                                r_maxv <= w_in_v;
                            end
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_last) begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_idx <= '0;
                    if (PW'(r_maxv) >= r_place) begin
                        for (int b = 0; b < RS_BUCKETS; b++) begin
                            r_cnt[b] <= '0;
                        end
                        r_state <= S_DG_RD;
                    end else begin
                        r_state <= S_EM_RD;
                    end
                end
                S_DG_RD: begin
                    r_state <= S_DG_DIV;
                end
                S_DG_DIV: begin
                    r_state <= S_DG_WAIT;
                end
                S_DG_WAIT: begin
                    if (w_div_done) begin
                        r_cnt[w_rem] <= r_cnt[w_rem] + CW'(1);
                        if (w_idx_last) begin
                            r_idx   <= '0;
                            r_pfx   <= '0;
                            r_acc   <= '0;
                            r_state <= S_PFX;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_DG_RD;
                        end
                    end
                end
                S_PFX: begin
                    // Turn counts into bucket start offsets
                    r_cnt[r_pfx] <= r_acc;
                    r_acc        <= r_acc + r_cnt[r_pfx];
                    if (r_pfx == w_base - RS_BASE_W'(1)) begin
                        r_state <= S_SC_RD;
                    end else begin
                        r_pfx <= r_pfx + RS_BASE_W'(1);
                    end
                end
                S_SC_RD: begin
                    r_state <= S_SC_WR;
                end
                S_SC_WR: begin
                    r_cnt[r_drd] <= r_cnt[r_drd] + CW'(1);
                    if (w_idx_last) begin
                        r_idx   <= '0;
                        r_state <= S_CP_RD;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_SC_RD;
                    end
                end
                S_CP_RD: begin
                    r_state <= S_CP_WR;
                end
                S_CP_WR: begin
                    if (w_idx_last) begin
                        r_idx   <= '0;
                        r_place <= PW'(r_place * w_base);
                        r_state <= S_CHK;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_CP_RD;
                    end
                end
                S_EM_RD: begin
                    r_state <= S_EM_OUT;
                end
                S_EM_OUT: begin
                    r_out_valid <= 1'b1;
                    r_out_value <= RS_VALUE_W'(r_rd[EW-1:SW]);
                    r_out_last  <= w_idx_last;
                    r_out_ovf   <= r_drop;
                    r_state     <= S_EM_HOLD;
                end
                S_EM_HOLD: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_count <= '0;
                            r_drop  <= 1'b0;
                            r_maxv  <= '0;
                            r_place <= PW'(1);
                            r_idx   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_last_res  = r_out_last;
    assign o_overflow  = r_out_ovf;

    // Never load and emit at once
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    // Store fill stays within capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("element count above capacity");

    // Scatter writes land inside the loaded set
    a_scatter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_WR) |-> (r_cnt[r_drd] < r_count))
        else $error("bucket write past the loaded set");

    // Divider results arrive only where the sequencer waits for them
    a_div_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DG_WAIT) && $past(r_state, 2) == S_DG_DIV)
        else $error("divider result outside the digit step");

    // Final transfer returns the block to loading with an empty store
    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_res) |=> (o_in_ready && r_count == '0))
        else $error("store not emptied after the final result");

    // Clamped base always selects a legal bucket count
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PFX) |-> (w_base >= RS_BASE_W'(RS_BASE_MIN)) &&
        (w_base_ok || r_base < RS_BASE_W'(RS_BASE_MIN) || r_base > RS_BASE_W'(RS_BUCKETS)))
        else $error("digit base outside the bucket range");

endmodule

// File: tb/lsd_radix_sort_core_tb.sv
// Self-checking testbench for lsd_radix_sort_core: directed sets, then random sets over many
// digit bases, checked against a radix-sort predictor built into the bench.
// Depends on rsort_pkg and the lsd_radix_sort_core RTL.
module lsd_radix_sort_core_tb;
    import rsort_pkg::*;

    localparam int STORE_DEPTH       = RS_MAX_ITEMS_DEF;
    localparam int TOTAL_ITEMS       = 470;
    localparam int PHASE_ITEMS       = 40;
    localparam int CFG_SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES      = 100;
    localparam int STALL_CYCLES      = 400;
    localparam int LIMIT_CYCLES      = 1500000;
    localparam int BASE_LIST_LEN     = 9;
    localparam int DIR_ROWS          = 12;

    typedef struct packed {
        logic [RS_VALUE_W-1:0] value;
        logic                  last;
        logic                  ovf;
    } sorted_word_t;

    typedef struct packed {
        logic [RS_VALUE_W-1:0] value;
        logic                  last;
        logic                  typed;
        logic [RS_VALUE_W-1:0] exp_value;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [RS_VALUE_W-1:0] i_value;
    logic                  i_last;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [RS_VALUE_W-1:0] o_value_res;
    logic                  o_last_res;
    logic                  o_overflow;
    logic                  i_cfg_we;
    logic [RS_BASE_W-1:0]  i_cfg_wdata;

    // Predictor state: the set being loaded, its drop flag and the written base
    logic [RS_VALUE_W-1:0] pending_set[$];
    logic                  pending_dropped;
    logic [RS_BASE_W-1:0]  cur_base;
    sorted_word_t          sorted_q[$];

    int errors;
    int items_sent;
    int sets_sent;
    int overflow_sets;
    int results_seen;
    int phases_run;
    logic [RS_VALUE_W-1:0] prev_value;

    // Single-element sets carry their expected result in the row
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{16'd0,     1'b1, 1'b1, 16'd0},
        '{16'hFFFF,  1'b1, 1'b1, 16'hFFFF},
        '{16'd1,     1'b1, 1'b1, 16'd1},
        '{16'd300,   1'b0, 1'b0, 16'd0},
        '{16'd7,     1'b0, 1'b0, 16'd0},
        '{16'hFFFF,  1'b0, 1'b0, 16'd0},
        '{16'd0,     1'b0, 1'b0, 16'd0},
        '{16'd7,     1'b1, 1'b0, 16'd0},
        '{16'hAAAA,  1'b0, 1'b0, 16'd0},
        '{16'h5555,  1'b0, 1'b0, 16'd0},
        '{16'h8000,  1'b0, 1'b0, 16'd0},
        '{16'h0001,  1'b1, 1'b0, 16'd0}
    };

    logic [RS_BASE_W-1:0] base_list [0:BASE_LIST_LEN-1] = '{
        5'd2, 5'd0, 5'd19, 5'd20, 5'd1, 5'd31, 5'd3, 5'd16, 5'd10
    };

    lsd_radix_sort_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sort the loaded set digit by digit, stable per pass, then queue the results
    task automatic sort_and_queue();
        int unsigned base;
        int unsigned place;
        int unsigned maxv;
        int unsigned acc;
        int unsigned d;
        int          counts [RS_BUCKETS];
        int          start [RS_BUCKETS];
        logic [RS_VALUE_W-1:0] scratch[$];
        base = cur_base;
        if (base < RS_BASE_MIN) base = RS_BASE_MIN;
        if (base > RS_BUCKETS) base = RS_BUCKETS;
        maxv = 0;
        foreach (pending_set[i]) if (pending_set[i] > maxv) maxv = pending_set[i];
        place = 1;
        while (maxv / place > 0) begin
            foreach (counts[b]) counts[b] = 0;
            foreach (pending_set[i]) counts[(pending_set[i] / place) % base]++;
            acc = 0;
            for (int b = 0; b < base; b++) begin
                start[b] = acc;
                acc += counts[b];
            end
            scratch = pending_set;
            foreach (pending_set[i]) begin
                d = (pending_set[i] / place) % base;
                scratch[start[d]] = pending_set[i];
                start[d]++;
            end
            pending_set = scratch;
            place = place * base;
        end
        foreach (pending_set[i])
            sorted_q.push_back('{pending_set[i], (i == pending_set.size() - 1), pending_dropped});
        if (pending_dropped) overflow_sets++;
        pending_set.delete();
        pending_dropped = 1'b0;
    endtask

    // Store or drop one accepted element; the marked one closes the set
    task automatic load_element(input logic [RS_VALUE_W-1:0] v, input logic l);
        if (pending_set.size() < STORE_DEPTH) pending_set.push_back(v);
        else pending_dropped = 1'b1;
        if (l) begin
            sort_and_queue();
            sets_sent++;
        end
    endtask

    // Offer one element, with random idle cycles ahead of it, and hold it until transfer
    task automatic send_item(input logic [RS_VALUE_W-1:0] v, input logic l);
        while (!(items_sent >= 150 && items_sent < 260) && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_last     <= l;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        items_sent++;
        prev_value = v;
        load_element(v, l);
    endtask

    function automatic logic [RS_VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return RS_VALUE_W'($urandom_range(65535));
        if (sel < 70) return RS_VALUE_W'($urandom_range(20));
        if (sel < 85) return prev_value;
        if (sel < 90) return '0;
        if (sel < 95) return '1;
        return RS_VALUE_W'(1) << $urandom_range(RS_VALUE_W - 1);
    endfunction

    task automatic send_set(input int count);
        for (int i = 0; i < count; i++) send_item(pick_value(), (i == count - 1));
    endtask

    task automatic write_base(input logic [RS_BASE_W-1:0] b);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_base = b;
        phases_run++;
    endtask

    // Drain idle: hold until every expected result is back, then let the block settle
    task automatic wait_drained();
        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random stalls, one long hold-off mid-set, field-by-field check
    initial begin : result_monitor
        sorted_word_t want;
        bit           stall_done;
        stall_done = 1'b0;
        forever begin
            i_out_ready <= (results_seen >= 100 && results_seen < 220) ||
                           ($urandom_range(99) >= 6);
            @(posedge i_clk);
            if (i_out_ready && o_out_valid === 1'b1) begin
                results_seen++;
                if (sorted_q.size() == 0) begin
                    $error("unexpected result transfer: value %0d last %0b overflow %0b",
                           o_value_res, o_last_res, o_overflow);
                    errors++;
                end else begin
                    want = sorted_q.pop_front();
                    if (o_value_res !== want.value) begin
                        $error("value_res: expected %0d, got %0d", want.value, o_value_res);
                        errors++;
                    end
                    if (o_last_res !== want.last) begin
                        $error("last_res: expected %0b, got %0b", want.last, o_last_res);
                        errors++;
                    end
                    if (o_overflow !== want.ovf) begin
                        $error("overflow: expected %0b, got %0b", want.ovf, o_overflow);
                        errors++;
                    end
                end
                // Hold off in the middle of a large set while the next set is offered
                if (!stall_done && !o_last_res && sorted_q.size() >= 20 &&
                    i_in_valid === 1'b1) begin
                    stall_done = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (STALL_CYCLES) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 20);
        $display("** lsd_radix_sort_core: FAILED **");
        $finish;
    end

    // Stimulus: reset, directed rows at the reset base, then random phases
    initial begin : stimulus
        int phase;
        int phase_start;
        logic [RS_BASE_W-1:0] base_pick;
        errors          = 0;
        items_sent      = 0;
        sets_sent       = 0;
        overflow_sets   = 0;
        results_seen    = 0;
        phases_run      = 0;
        prev_value      = '0;
        pending_dropped = 1'b0;
        cur_base        = RS_BASE_W'(RS_BASE_RESET);
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_value     <= '0;
        i_last      <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item(dir_rows[r].value, dir_rows[r].last);
            if (dir_rows[r].typed) begin
                void'(sorted_q.pop_back());
                sorted_q.push_back('{dir_rows[r].exp_value, 1'b1, 1'b0});
            end
        end

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            i_in_valid <= 1'b0;
            wait_drained();
            base_pick = (phase < BASE_LIST_LEN) ? base_list[phase]
                                                : RS_BASE_W'($urandom_range(31));
            write_base(base_pick);
            phase_start = items_sent;
            // Full store with the marked element dropped, then exactly full and overfull
            if (phase == 1) send_set(STORE_DEPTH + 1);
            if (phase == 3) begin
                send_set(STORE_DEPTH);
                send_set(STORE_DEPTH + 6);
            end
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < TOTAL_ITEMS)
                send_set(($urandom_range(99) < 85) ? $urandom_range(8, 1)
                                                   : $urandom_range(40, 9));
            phase++;
        end
        i_in_valid <= 1'b0;

        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sorted %0d elements in %0d sets (%0d with dropped elements) over %0d bases,",
                 items_sent, sets_sent, overflow_sets, phases_run + 1);
        $display("with %0d results checked under random stalls on both sides.", results_seen);
        if (errors == 0) begin
            $display("** lsd_radix_sort_core: PASSED **");
        end else begin
            $display("** lsd_radix_sort_core: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rsort_pkg.sv
hw/rtl/rsort_div.sv
hw/rtl/lsd_radix_sort_core.sv
tb/lsd_radix_sort_core_tb.sv
